FILE: src/stepper_microstep_sequencer_defines.svh
// ----------------------------------------------------------------------------
// Stepper microstep sequencer assertion macros
// Concurrent assertion wrappers on clk, with and without reset masking.
// ----------------------------------------------------------------------------
`ifndef STEPPER_MICROSTEP_SEQUENCER_DEFINES_SVH
`define STEPPER_MICROSTEP_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS
`define SMS_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sms assertion failed");
`define SMS_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("sms assertion failed");
`else
`define SMS_ASSERT(name, prop)
`define SMS_ASSERT_ALWAYS(name, prop)
`endif

`endif

FILE: src/sms_pkg.sv
// ----------------------------------------------------------------------------
// Stepper microstep sequencer package
// Transfer types, register indexes, sine table and drive word encoding.
// ----------------------------------------------------------------------------
package sms_pkg;

  localparam int MICROSTEPS_PER_STEP = 8;
  localparam int MSTEP_CLAMPED = (MICROSTEPS_PER_STEP < 4) ? 4 :
                                 (MICROSTEPS_PER_STEP > 8) ? 8 : MICROSTEPS_PER_STEP;
  localparam logic [3:0] MSTEP_N = 4'(MSTEP_CLAMPED);
  localparam int SINE_ROW = MSTEP_CLAMPED - 4;

  localparam int INTERVAL_W = 24;
  localparam int POS_W      = 16;
  localparam int REMAIN_W   = 23;
  localparam int CFG_DATA_W = 24;

  localparam logic [INTERVAL_W-1:0] STEP_INTERVAL_RST = 24'd1000;
  localparam logic [POS_W-1:0]      POSITION_WRAP_RST = 16'd1600;

  typedef enum logic {
    CFG_STEP_INTERVAL = 1'b0,
    CFG_POSITION_WRAP = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic               cmd;
    logic signed [23:0] move_steps;
  } sms_in_t;

  typedef struct packed {
    logic [31:0] drive_word;
    logic [15:0] step_position;
    logic [2:0]  microstep_index;
    logic        move_done;
  } sms_out_t;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_MOVE = 1'b1;

  localparam logic [3:0] PH_A_POS = 4'b1000;
  localparam logic [3:0] PH_A_NEG = 4'b0100;
  localparam logic [3:0] PH_B_POS = 4'b0010;
  localparam logic [3:0] PH_B_NEG = 4'b0001;

  localparam logic [7:0] COUNT_SUM = 8'd142;
  localparam int DW_COUNT2_LSB = 25;
  localparam int DW_PHASE2_LSB = 21;
  localparam int DW_COUNT1_LSB = 15;
  localparam int DW_PHASE1_LSB = 11;
  localparam int DW_COUNT0_LSB = 4;

  // trunc(100*sin(k*pi/(2N))), one row per N = 4..8
  localparam logic [6:0] SINE_ROWS [0:4][0:8] = '{
    '{7'd0, 7'd38, 7'd70, 7'd92, 7'd100, 7'd0, 7'd0, 7'd0, 7'd0},
    '{7'd0, 7'd30, 7'd58, 7'd80, 7'd95, 7'd100, 7'd0, 7'd0, 7'd0},
    '{7'd0, 7'd25, 7'd50, 7'd70, 7'd86, 7'd96, 7'd100, 7'd0, 7'd0},
    '{7'd0, 7'd22, 7'd43, 7'd62, 7'd78, 7'd90, 7'd97, 7'd100, 7'd0},
    '{7'd0, 7'd19, 7'd38, 7'd55, 7'd70, 7'd83, 7'd92, 7'd98, 7'd100}
  };

  function automatic logic [31:0] drive_word_calc(input logic [1:0] quad,
                                                  input logic [2:0] micro);
    logic [3:0] rc;
    logic [6:0] lo;
    logic [6:0] hi;
    logic [6:0] mag_a;
    logic [6:0] mag_b;
    logic [6:0] cnt0;
    logic [6:0] cnt2;
    logic [7:0] cnt1;
    logic [3:0] ph0;
    logic [3:0] ph2;
    logic       neg_a;
    logic       neg_b;
    rc    = ({1'b0, micro} >= MSTEP_N) ? (MSTEP_N - 4'd1) : {1'b0, micro};
    lo    = SINE_ROWS[SINE_ROW][rc];
    hi    = SINE_ROWS[SINE_ROW][MSTEP_N - rc];
    mag_a = quad[0] ? hi : lo;
    mag_b = quad[0] ? lo : hi;
    neg_a = quad[1];
    neg_b = (quad == 2'd1) || (quad == 2'd2);
    cnt0  = (mag_a != 7'd0) ? (mag_a - 7'd2) : 7'd0;
    cnt2  = (mag_b != 7'd0) ? (mag_b - 7'd4) : 7'd0;
    ph0   = (mag_a == 7'd0) ? 4'd0 : (neg_a ? PH_A_NEG : PH_A_POS);
    ph2   = (mag_b == 7'd0) ? 4'd0 : (neg_b ? PH_B_NEG : PH_B_POS);
    cnt1  = COUNT_SUM - {1'b0, cnt0} - {1'b0, cnt2};
    return (32'(cnt2) << DW_COUNT2_LSB) | (32'(ph2) << DW_PHASE2_LSB) |
           (32'(cnt1) << DW_COUNT1_LSB) | (32'(ph0 | ph2) << DW_PHASE1_LSB) |
           (32'(cnt0) << DW_COUNT0_LSB) | 32'(ph0);
  endfunction

endpackage

FILE: src/stepper_microstep_sequencer.sv
// ----------------------------------------------------------------------------
// Stepper microstep sequencer
// Paced sine/cosine microstepping for a two-coil stepper motor.
// ----------------------------------------------------------------------------
// Takes one command (tick or move) per clock while in_stall is low. Each
// transfer is handled in the cycle it is accepted, so the sustained rate is
// one item per cycle while neither stall holds it. The elapsed counter compare,
// the position and index update and the sine table drive word lookup all sit
// ahead of one output register, which shows a microstep result for each tick
// that steps; a skid register behind it lets the input keep flowing for one
// more result while out_stall is high; in_stall rises once both hold a result
// or in reset. A move replaces any pending move; a zero count is ignored.
`include "stepper_microstep_sequencer_defines.svh"

module stepper_microstep_sequencer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  sms_pkg::sms_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output sms_pkg::sms_out_t              out_data,
  input  logic                           cfg_we,
  input  sms_pkg::cfg_index_t            cfg_index,
  input  logic [sms_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sms_pkg::*;

  logic [INTERVAL_W-1:0] step_interval_r;
  logic [POS_W-1:0]      position_wrap_r;
  logic [INTERVAL_W-1:0] elapsed_r,   elapsed_nxt;
  logic [REMAIN_W-1:0]   remaining_r, remaining_nxt;
  logic                  forward_r,   forward_nxt;
  logic [POS_W-1:0]      position_r,  position_nxt;
  logic [2:0]            micro_idx_r, micro_idx_nxt;
  logic                  out_valid_r;
  sms_out_t              out_data_r;
  logic                  skid_valid_r;
  sms_out_t              skid_data_r;

  logic                  in_fire;
  logic                  out_fire;
  logic                  step_fire;
  logic [INTERVAL_W-1:0] elapsed_inc;
  logic [23:0]           move_neg;
  logic [2:0]            idx_fwd;
  logic [POS_W-1:0]      pos_fwd;
  logic [POS_W-1:0]      pos_rev_base;
  sms_out_t              res;

  assign in_stall  = skid_valid_r | ~rst_n;
  assign in_fire   = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_fire  = out_valid_r & ~out_stall;

  assign elapsed_inc  = (elapsed_r == '1) ? elapsed_r : elapsed_r + 1'b1;
  assign step_fire    = in_fire && (in_data.cmd == CMD_TICK) &&
                        (elapsed_inc >= step_interval_r) && (remaining_r != '0);
  assign move_neg     = 24'(-in_data.move_steps);
  assign idx_fwd      = micro_idx_r + 3'd1;
  assign pos_fwd      = position_r + 1'b1;
  assign pos_rev_base = (position_r == '0) ? position_wrap_r : position_r;

  always_comb begin
    elapsed_nxt   = elapsed_r;
    remaining_nxt = remaining_r;
    forward_nxt   = forward_r;
    position_nxt  = position_r;
    micro_idx_nxt = micro_idx_r;
    if (in_fire && (in_data.cmd == CMD_MOVE)) begin
      if (in_data.move_steps != '0) begin
        forward_nxt = ~in_data.move_steps[23];
        if (in_data.move_steps[23]) begin
          remaining_nxt = move_neg[23] ? '1 : move_neg[REMAIN_W-1:0];
        end else begin
          remaining_nxt = in_data.move_steps[REMAIN_W-1:0];
        end
      end
    end else if (in_fire) begin
      elapsed_nxt = elapsed_inc;
      if (step_fire) begin
        elapsed_nxt   = '0;
        remaining_nxt = remaining_r - 1'b1;
        if (forward_r) begin
          if ({1'b0, idx_fwd} >= MSTEP_N) begin
            micro_idx_nxt = 3'd0;
            position_nxt  = (pos_fwd == position_wrap_r) ? '0 : pos_fwd;
          end else begin
            micro_idx_nxt = idx_fwd;
          end
        end else if (micro_idx_r == 3'd0) begin
          micro_idx_nxt = 3'(MSTEP_N - 4'd1);
          position_nxt  = pos_rev_base - 1'b1;
        end else begin
          micro_idx_nxt = micro_idx_r - 3'd1;
        end
      end
    end
  end

  always_comb begin
    res.drive_word      = drive_word_calc(position_nxt[1:0], micro_idx_nxt);
    res.step_position   = position_nxt;
    res.microstep_index = micro_idx_nxt;
    res.move_done       = (remaining_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_interval_r <= STEP_INTERVAL_RST;
      position_wrap_r <= POSITION_WRAP_RST;
      elapsed_r       <= '0;
      remaining_r     <= '0;
      forward_r       <= 1'b0;
      position_r      <= '0;
      micro_idx_r     <= '0;
      out_valid_r     <= 1'b0;
      skid_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_STEP_INTERVAL: step_interval_r <= cfg_wdata[INTERVAL_W-1:0];
          CFG_POSITION_WRAP: position_wrap_r <= cfg_wdata[POS_W-1:0];
          default: ;
        endcase
      end
      elapsed_r   <= elapsed_nxt;
      remaining_r <= remaining_nxt;
      forward_r   <= forward_nxt;
      position_r  <= position_nxt;
      micro_idx_r <= micro_idx_nxt;
      if (!out_valid_r || out_fire) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          out_data_r   <= skid_data_r;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= step_fire;
          out_data_r  <= res;
        end
      end else if (step_fire) begin
        skid_valid_r <= 1'b1;
        skid_data_r  <= res;
      end
    end
  end

  `SMS_ASSERT(a_skid_behind_out, skid_valid_r |-> out_valid_r)
  `SMS_ASSERT(a_step_consumes_one, step_fire |=> (remaining_r == $past(remaining_r) - 1'b1))
  `SMS_ASSERT(a_index_in_range, ({1'b0, micro_idx_r} < MSTEP_N))
  `SMS_ASSERT_ALWAYS(a_no_accept_in_reset, !rst_n |-> !in_fire)

endmodule
